@@ rtl/mwrl_pkg.sv @@
package mwrl_pkg;

   localparam int NUM_POLICIES_DEF = 4;
   localparam int MAX_WINDOWS_DEF = 4;

   localparam int MS_PER_S = 1000;
   localparam logic [15:0] SKEW_RESET = 16'd250;
   localparam logic [47:0] T48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] HIT_MAX = 16'hFFFF;

   localparam logic [2:0] FN_QUERY = 3'd0;
   localparam logic [2:0] FN_NOTE = 3'd1;
   localparam logic [2:0] FN_SEED = 3'd2;
   localparam logic [2:0] FN_OBSERVED = 3'd3;
   localparam logic [2:0] FN_STATE = 3'd4;
   localparam logic [2:0] FN_RETRY = 3'd5;

   typedef struct packed {
      logic [15:0] limit;
      logic [15:0] period;
      logic [15:0] hits;
      logic [47:0] start;
   } win_entry_type;

endpackage

@@ rtl/mwrl_win_ram.sv @@
module mwrl_win_ram #(
   parameter int DEPTH = mwrl_pkg::NUM_POLICIES_DEF * mwrl_pkg::MAX_WINDOWS_DEF,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  mwrl_pkg::win_entry_type wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output mwrl_pkg::win_entry_type rd_data
);

   mwrl_pkg::win_entry_type mem [DEPTH];
   mwrl_pkg::win_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/multi_window_rate_limiter.sv @@
// multi-window fixed-window rate limiter, one set of windows per policy
//
// req_ channel: one transfer per item (func, policy, now_ms, rule fields).
// rsp_ channel: exactly one transfer per item, rsp_wait_ms and rsp_rule_dropped.
// csr_ channel: writes skew_margin_ms; csr_ready is always high, write only
// while no item is in flight.
//
// the window state lives in a single-port-write, registered-read ram; an item
// walks the windows of its policy one at a time, each through read, end time,
// compare and write back. no window is walked for retry-after items, seed
// rules and rules that find staging full; a rule item adds a staging step
// and, on commit, a write per staged rule. one item is worked on at a time
// and req_stall is high while it is.
//
// the result sits in an output register: a stalled receiver holds it, and the
// next item is taken meanwhile, waiting only to hand over its own result.
// synchronous reset clears the window counts, block times, staging count and
// sets skew_margin_ms to 250; no clearing pass, the ram is ready at once.
module multi_window_rate_limiter #(
   parameter int NUM_POLICIES = mwrl_pkg::NUM_POLICIES_DEF,
   parameter int MAX_WINDOWS = mwrl_pkg::MAX_WINDOWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [1:0]  req_policy,
   input  logic [47:0] req_now_ms,
   input  logic [15:0] req_rule_limit,
   input  logic [15:0] req_window_period,
   input  logic [15:0] req_observed_hits,
   input  logic [15:0] req_seconds,
   input  logic        req_run_first,
   input  logic        req_run_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [47:0] rsp_wait_ms,
   output logic        rsp_rule_dropped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int DEPTH = NUM_POLICIES * MAX_WINDOWS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PIW = (NUM_POLICIES > 1) ? $clog2(NUM_POLICIES) : 1;
   localparam int CW = $clog2(MAX_WINDOWS + 1);
   localparam int KW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_M1 = 4'd1;
   localparam logic [3:0] ST_M2 = 4'd2;
   localparam logic [3:0] ST_RD = 4'd3;
   localparam logic [3:0] ST_E1 = 4'd4;
   localparam logic [3:0] ST_E2 = 4'd5;
   localparam logic [3:0] ST_E3 = 4'd6;
   localparam logic [3:0] ST_APPEND = 4'd7;
   localparam logic [3:0] ST_COMMIT = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   logic [3:0] state_ff, state_in;

   // latched item
   logic [2:0]  func_ff;
   logic [1:0]  policy_ff;
   logic [47:0] now_ff;
   logic [15:0] lim_ff, per_ff, obs_ff, secs_ff;
   logic        first_ff, last_ff;

   logic [15:0] skew_ff;
   logic [CW-1:0] count_ff [NUM_POLICIES];
   logic [47:0]   block_ff [NUM_POLICIES];

   logic [15:0] new_limit_ff [MAX_WINDOWS];
   logic [15:0] new_period_ff [MAX_WINDOWS];
   logic [15:0] new_hits_ff [MAX_WINDOWS];
   logic [47:0] new_start_ff [MAX_WINDOWS];
   logic [CW-1:0] new_count_ff;
   logic          seed_open_ff;

   logic [CW-1:0] n_ff, idx_ff, commit_c_ff;
   logic [25:0]   prod_ff;
   logic [47:0]   until_ff, delay_ff;
   logic          dropped_ff, match_ff, found_ff;
   logic [15:0]   found_hits_ff;
   logic [47:0]   found_start_ff;
   logic          bad_ff;

   mwrl_pkg::win_entry_type win_ff, rd_data, wr_data;
   logic [48:0] ends_ff, diff_ff;
   logic        closed_ff;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr, cur_addr;

   logic            rsp_valid_ff;
   logic [47:0]     rsp_delay_ff;
   logic            rsp_dropped_ff;

   logic [PIW-1:0] pidx;
   logic           is_rule, full_now, load_rsp;
   logic [CW-1:0]  cnt_new;
   logic [48:0]    until_sum;
   logic [49:0]    cand_sum;
   logic [47:0]    cand;
   logic [15:0]    hits_base;

   assign pidx = PIW'(policy_ff);
   assign is_rule = func_ff inside {mwrl_pkg::FN_SEED, mwrl_pkg::FN_OBSERVED};
   assign full_now = (new_count_ff >= CW'(MAX_WINDOWS));
   assign cnt_new = full_now ? new_count_ff : new_count_ff + CW'(1);
   assign cur_addr = AW'(int'(policy_ff) * MAX_WINDOWS + int'(idx_ff));
   assign until_sum = {1'b0, now_ff} + 49'(prod_ff);
   assign cand_sum = {1'b0, diff_ff} + 50'(skew_ff);
   assign cand = (cand_sum > 50'(mwrl_pkg::T48)) ? mwrl_pkg::T48 : cand_sum[47:0];
   assign hits_base = (win_ff.hits == 16'd0 || closed_ff) ? 16'd0 : win_ff.hits;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_wait_ms = rsp_delay_ff;
   assign rsp_rule_dropped = rsp_dropped_ff;

   assign rd_en = (state_ff == ST_RD);
   assign rd_addr = cur_addr;

   // write port: window write-back or list commit
   always_comb begin
      wr_en = 1'b0;
      wr_addr = cur_addr;
      wr_data = win_ff;
      if (state_ff == ST_E3) begin
         case (func_ff)
            mwrl_pkg::FN_NOTE: begin
               if (win_ff.period != 16'd0) begin
                  wr_en = 1'b1;
                  if (hits_base == 16'd0) begin
                     wr_data.start = now_ff;
                  end
                  wr_data.hits = (hits_base == mwrl_pkg::HIT_MAX) ? hits_base
                                                                  : hits_base + 16'd1;
               end
            end
            mwrl_pkg::FN_STATE: begin
               if (win_ff.period == per_ff) begin
                  wr_en = 1'b1;
                  if (win_ff.hits == 16'd0) begin
                     wr_data.start = now_ff;
                  end
                  if (obs_ff > win_ff.hits) begin
                     wr_data.hits = obs_ff;
                  end
               end
            end
            default: wr_en = 1'b0;
         endcase
      end else if (state_ff == ST_COMMIT) begin
         wr_en = 1'b1;
         wr_data.limit = new_limit_ff[KW'(idx_ff)];
         wr_data.period = new_period_ff[KW'(idx_ff)];
         wr_data.hits = new_hits_ff[KW'(idx_ff)];
         wr_data.start = new_start_ff[KW'(idx_ff)];
      end
   end

   mwrl_win_ram #(
      .DEPTH(DEPTH),
      .AW(AW)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_M1;
         ST_M1: state_in = ST_M2;
         ST_M2: begin
            if (bad_ff || func_ff == mwrl_pkg::FN_RETRY) begin
               state_in = ST_DONE;
            end else if (is_rule) begin
               // a first rule empties staging, so it is never full for it
               if (func_ff == mwrl_pkg::FN_OBSERVED && (first_ff || !full_now) &&
                   n_ff != '0) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_APPEND;
               end
            end else begin
               state_in = (n_ff != '0) ? ST_RD : ST_DONE;
            end
         end
         ST_RD: state_in = ST_E1;
         ST_E1: state_in = ST_E2;
         ST_E2: state_in = ST_E3;
         ST_E3: begin
            if (idx_ff + CW'(1) < n_ff) begin
               state_in = ST_RD;
            end else begin
               state_in = is_rule ? ST_APPEND : ST_DONE;
            end
         end
         ST_APPEND: begin
            if (last_ff && (!seed_open_ff || n_ff == '0) && cnt_new != '0) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COMMIT: if (idx_ff + CW'(1) == commit_c_ff) state_in = ST_DONE;
         ST_DONE: if (load_rsp) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         skew_ff <= mwrl_pkg::SKEW_RESET;
         new_count_ff <= '0;
         seed_open_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_POLICIES; p++) begin
            count_ff[p] <= '0;
            block_ff[p] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            skew_ff <= csr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_M2 && !bad_ff && is_rule && first_ff) begin
            new_count_ff <= '0;
            seed_open_ff <= (func_ff == mwrl_pkg::FN_SEED);
         end
         if (state_ff == ST_APPEND) begin
            if (last_ff) begin
               new_count_ff <= '0;
               if ((!seed_open_ff || n_ff == '0) && cnt_new == '0) begin
                  count_ff[pidx] <= '0;
               end
            end else begin
               new_count_ff <= cnt_new;
            end
         end
         if (state_ff == ST_COMMIT && idx_ff + CW'(1) == commit_c_ff) begin
            count_ff[pidx] <= commit_c_ff;
         end
         if (load_rsp && !bad_ff && secs_ff != 16'd0 && until_ff > block_ff[pidx] &&
             (func_ff == mwrl_pkg::FN_RETRY || (func_ff == mwrl_pkg::FN_STATE && match_ff))) begin
            block_ff[pidx] <= until_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         func_ff <= req_func;
         policy_ff <= req_policy;
         now_ff <= req_now_ms;
         lim_ff <= req_rule_limit;
         per_ff <= req_window_period;
         obs_ff <= req_observed_hits;
         secs_ff <= req_seconds;
         first_ff <= req_run_first;
         last_ff <= req_run_last;
      end
      case (state_ff)
         ST_M1: begin
            bad_ff <= (int'(policy_ff) >= NUM_POLICIES) ||
                      (func_ff > mwrl_pkg::FN_RETRY);
            prod_ff <= 26'(secs_ff) * 26'(mwrl_pkg::MS_PER_S);
            n_ff <= count_ff[pidx];
            idx_ff <= '0;
            delay_ff <= '0;
            dropped_ff <= 1'b0;
            match_ff <= 1'b0;
            found_ff <= 1'b0;
         end
         ST_M2: begin
            until_ff <= (until_sum > 49'(mwrl_pkg::T48)) ? mwrl_pkg::T48 : until_sum[47:0];
            if (func_ff == mwrl_pkg::FN_QUERY && block_ff[pidx] > now_ff) begin
               delay_ff <= block_ff[pidx] - now_ff;
            end
         end
         ST_E1: begin
            win_ff <= rd_data;
            ends_ff <= {1'b0, rd_data.start} +
                       49'(26'(rd_data.period) * 26'(mwrl_pkg::MS_PER_S));
         end
         ST_E2: begin
            closed_ff <= ({1'b0, now_ff} >= ends_ff);
            diff_ff <= ends_ff - {1'b0, now_ff};
         end
         ST_E3: begin
            idx_ff <= idx_ff + CW'(1);
            if (func_ff == mwrl_pkg::FN_QUERY && win_ff.limit != 16'd0 &&
                win_ff.period != 16'd0 && !closed_ff && win_ff.hits >= win_ff.limit &&
                cand > delay_ff) begin
               delay_ff <= cand;
            end
            if (func_ff == mwrl_pkg::FN_STATE && win_ff.period == per_ff) begin
               match_ff <= 1'b1;
            end
            if (func_ff == mwrl_pkg::FN_OBSERVED && !found_ff && win_ff.period == per_ff) begin
               found_ff <= 1'b1;
               found_hits_ff <= win_ff.hits;
               found_start_ff <= win_ff.start;
            end
         end
         ST_APPEND: begin
            idx_ff <= '0;
            commit_c_ff <= cnt_new;
            if (full_now) begin
               dropped_ff <= 1'b1;
            end else begin
               new_limit_ff[KW'(new_count_ff)] <= lim_ff;
               new_period_ff[KW'(new_count_ff)] <= per_ff;
               new_hits_ff[KW'(new_count_ff)] <= found_ff ? found_hits_ff : 16'd0;
               if (func_ff == mwrl_pkg::FN_SEED) begin
                  new_start_ff[KW'(new_count_ff)] <= '0;
               end else begin
                  new_start_ff[KW'(new_count_ff)] <= found_ff ? found_start_ff : now_ff;
               end
            end
         end
         ST_COMMIT: idx_ff <= idx_ff + CW'(1);
         default: begin
         end
      endcase
      if (load_rsp) begin
         rsp_delay_ff <= bad_ff ? 48'd0 : delay_ff;
         rsp_dropped_ff <= bad_ff ? 1'b0 : dropped_ff;
      end
   end

`ifndef ASSERT_OFF
   a_wr_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_E3 || state_ff == ST_COMMIT))
      else $error("window ram written outside write-back or commit");

   a_staging_bound: assert property (@(posedge clock) disable iff (reset)
      new_count_ff <= CW'(MAX_WINDOWS))
      else $error("staging count beyond window capacity");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised without a finished item");

   a_read_then_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_E1) |-> $past(state_ff) == ST_RD)
      else $error("window data used without a read");
`endif

endmodule

@@ tb/sv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NP = 4;
   localparam int NW = 4;

   typedef struct {
      logic [2:0]  func;
      logic [1:0]  policy;
      logic [47:0] now_ms;
      logic [15:0] rule_limit;
      logic [15:0] window_period;
      logic [15:0] observed_hits;
      logic [15:0] seconds;
      logic        run_first;
      logic        run_last;
   } req_type;

   typedef struct {
      req_type     r;
      bit          known;
      logic [47:0] delay;
      logic        dropped;
   } row_type;

   typedef struct {
      logic [47:0] delay;
      logic        dropped;
   } rsp_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_func;
   logic [1:0] req_policy;
   logic [47:0] req_now_ms;
   logic [15:0] req_rule_limit, req_window_period, req_observed_hits, req_seconds;
   logic req_run_first, req_run_last;
   logic rsp_valid, rsp_stall;
   logic [47:0] rsp_wait_ms;
   logic rsp_rule_dropped;
   logic csr_valid, csr_ready;
   logic [15:0] csr_data;

   multi_window_rate_limiter DUT (.*);

   // limiter shadow state
   logic [15:0] sh_limit [NP*NW];
   logic [15:0] sh_period [NP*NW];
   logic [15:0] sh_hits [NP*NW];
   logic [47:0] sh_start [NP*NW];
   int          sh_count [NP];
   logic [47:0] sh_block [NP];
   logic [15:0] stg_limit [NW];
   logic [15:0] stg_period [NW];
   logic [15:0] stg_hits [NW];
   logic [47:0] stg_start [NW];
   int          stg_count;
   bit          stg_seed;
   logic [15:0] skew_ms;

   rsp_type pending_rsp [$];
   int   errors = 0;
   bit   quiet = 0;
   int   hold_len = 0;
   logic [47:0] t_now;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [47:0] sat48(logic [63:0] v);
      return (v > {16'd0, mwrl_pkg::T48}) ? mwrl_pkg::T48 : v[47:0];
   endfunction

   function automatic logic [63:0] win_close(int w);
      return {16'd0, sh_start[w]} + 64'(sh_period[w]) * 64'(mwrl_pkg::MS_PER_S);
   endfunction

   task automatic raise_block(int p, logic [47:0] now, logic [15:0] secs);
      logic [47:0] u;
      u = sat48({16'd0, now} + 64'(secs) * 64'(mwrl_pkg::MS_PER_S));
      if (u > sh_block[p]) sh_block[p] = u;
   endtask

   task automatic predict_limiter(req_type r, output rsp_type o);
      int p, base, n, w, k, c;
      logic [63:0] ends, cand;
      o.delay = 0;
      o.dropped = 0;
      if (r.func > mwrl_pkg::FN_RETRY) return;
      p = r.policy;
      base = p * NW;
      n = sh_count[p];
      case (r.func)
         mwrl_pkg::FN_QUERY: begin
            if (sh_block[p] > r.now_ms) o.delay = sh_block[p] - r.now_ms;
            for (int i = 0; i < n; i++) begin
               w = base + i;
               if (sh_limit[w] == 0 || sh_period[w] == 0) continue;
               ends = win_close(w);
               if (64'(r.now_ms) >= ends || sh_hits[w] < sh_limit[w]) continue;
               cand = ends - 64'(r.now_ms) + 64'(skew_ms);
               if (sat48(cand) > o.delay) o.delay = sat48(cand);
            end
         end
         mwrl_pkg::FN_NOTE: begin
            for (int i = 0; i < n; i++) begin
               w = base + i;
               if (sh_period[w] == 0) continue;
               if (sh_hits[w] == 0 || 64'(r.now_ms) >= win_close(w)) begin
                  sh_start[w] = r.now_ms;
                  sh_hits[w] = 0;
               end
               if (sh_hits[w] < mwrl_pkg::HIT_MAX) sh_hits[w]++;
            end
         end
         mwrl_pkg::FN_SEED, mwrl_pkg::FN_OBSERVED: begin
            if (r.run_first) begin
               stg_count = 0;
               stg_seed = (r.func == mwrl_pkg::FN_SEED);
            end
            if (stg_count >= NW) o.dropped = 1;
            else begin
               k = stg_count;
               stg_limit[k] = r.rule_limit;
               stg_period[k] = r.window_period;
               stg_hits[k] = 0;
               stg_start[k] = (r.func == mwrl_pkg::FN_SEED) ? 48'd0 : r.now_ms;
               if (r.func == mwrl_pkg::FN_OBSERVED) begin
                  for (int i = 0; i < n; i++) begin
                     if (sh_period[base+i] == r.window_period) begin
                        stg_hits[k] = sh_hits[base+i];
                        stg_start[k] = sh_start[base+i];
                        break;
                     end
                  end
               end
               stg_count = k + 1;
            end
            if (r.run_last) begin
               if (!stg_seed || n == 0) begin
                  c = stg_count;
                  for (int i = 0; i < c; i++) begin
                     sh_limit[base+i] = stg_limit[i];
                     sh_period[base+i] = stg_period[i];
                     sh_hits[base+i] = stg_hits[i];
                     sh_start[base+i] = stg_start[i];
                  end
                  sh_count[p] = c;
               end
               stg_count = 0;
            end
         end
         mwrl_pkg::FN_STATE: begin
            for (int i = 0; i < n; i++) begin
               w = base + i;
               if (sh_period[w] != r.window_period) continue;
               if (sh_hits[w] == 0) sh_start[w] = r.now_ms;
               if (r.observed_hits > sh_hits[w]) sh_hits[w] = r.observed_hits;
               if (r.seconds > 0) raise_block(p, r.now_ms, r.seconds);
            end
         end
         default: begin
            if (r.seconds > 0) raise_block(p, r.now_ms, r.seconds);
         end
      endcase
   endtask

   // sender: one transfer per call, prediction taken at the accepting edge
   task automatic send_req(req_type r, bit known = 0, logic [47:0] kd = 0, logic kdr = 0);
      int gap;
      rsp_type o;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= r.func;
      req_policy <= r.policy;
      req_now_ms <= r.now_ms;
      req_rule_limit <= r.rule_limit;
      req_window_period <= r.window_period;
      req_observed_hits <= r.observed_hits;
      req_seconds <= r.seconds;
      req_run_first <= r.run_first;
      req_run_last <= r.run_last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_limiter(r, o);
      if (known) begin
         o.delay = kd;
         o.dropped = kdr;
      end
      pending_rsp = {pending_rsp, o};
   endtask

   // receiver
   initial begin
      int k;
      rsp_type e;
      rsp_stall = 0;
      @(negedge reset);
      forever begin
         k = quiet ? 0 : $urandom_range(0, 14);
         if (hold_len > 0) begin
            k = hold_len;
            hold_len = 0;
         end
         if (k > 0) begin
            rsp_stall <= 1;
            repeat (k) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transfer wait=%0d dropped=%0b", $time,
                     rsp_wait_ms, rsp_rule_dropped);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_wait_ms !== e.delay) begin
               $display("%0t: wait_ms expected %0d actual %0d", $time, e.delay,
                        rsp_wait_ms);
               errors++;
            end
            if (rsp_rule_dropped !== e.dropped) begin
               $display("%0t: rule_dropped expected %0b actual %0b", $time, e.dropped,
                        rsp_rule_dropped);
               errors++;
            end
         end
      end
   end

   task automatic write_skew(logic [15:0] v);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      skew_ms = v;
      csr_valid <= 0;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   function automatic logic [15:0] pick_period();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom());
         3, 4: return 16'd2;
         default: return 16'd1;
      endcase
   endfunction

   function automatic req_type base_req();
      req_type r;
      if ($urandom_range(0, 40) == 0) t_now = rand48();
      else t_now = t_now + $urandom_range(0, 700);
      r.func = mwrl_pkg::FN_QUERY;
      r.policy = 2'($urandom_range(0, 3));
      r.now_ms = t_now;
      r.rule_limit = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
      r.window_period = pick_period();
      r.observed_hits = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5));
      r.seconds = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
      r.run_first = 1'($urandom_range(0, 1));
      r.run_last = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // random traffic, returns the number of transfers sent
   task automatic random_burst(output int sent);
      req_type r;
      int sel, len;
      logic [2:0] kind;
      logic [1:0] pol;
      sent = 0;
      r = base_req();
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         r.func = mwrl_pkg::FN_QUERY;
      end else if (sel < 60) begin
         r.func = mwrl_pkg::FN_NOTE;
      end else if (sel < 78) begin
         // well-formed rule list
         kind = $urandom_range(0, 1) ? mwrl_pkg::FN_SEED : mwrl_pkg::FN_OBSERVED;
         len = $urandom_range(1, 5);
         pol = r.policy;
         for (int i = 0; i < len; i++) begin
            if (i > 0) r = base_req();
            r.policy = pol;
            r.func = kind;
            r.run_first = (i == 0);
            r.run_last = (i == len - 1);
            send_req(r);
            sent++;
         end
         return;
      end else if (sel < 87) begin
         r.func = mwrl_pkg::FN_STATE;
      end else if (sel < 95) begin
         r.func = mwrl_pkg::FN_RETRY;
      end else if (sel < 98) begin
         r.func = $urandom_range(0, 1) ? mwrl_pkg::FN_SEED : mwrl_pkg::FN_OBSERVED;
      end else begin
         r.func = 3'($urandom_range(6, 7));
      end
      send_req(r);
      sent++;
   endtask

   row_type dir [$];

   function automatic row_type mk(logic [2:0] f, logic [1:0] p, logic [47:0] now,
                                  logic [15:0] lim, logic [15:0] per, logic [15:0] obs,
                                  logic [15:0] secs, logic first, logic last,
                                  bit known = 0, logic [47:0] d = 0, logic dr = 0);
      row_type x;
      x.r = '{f, p, now, lim, per, obs, secs, first, last};
      x.known = known;
      x.delay = d;
      x.dropped = dr;
      return x;
   endfunction

   initial begin
      int sent, total;
      logic [15:0] skews [4];
      reset = 1;
      req_valid = 0;
      req_func = 0;
      req_policy = 0;
      req_now_ms = 0;
      req_rule_limit = 0;
      req_window_period = 0;
      req_observed_hits = 0;
      req_seconds = 0;
      req_run_first = 0;
      req_run_last = 0;
      csr_valid = 0;
      csr_data = 0;
      foreach (sh_limit[i]) begin
         sh_limit[i] = 0; sh_period[i] = 0; sh_hits[i] = 0; sh_start[i] = 0;
      end
      foreach (sh_count[i]) begin
         sh_count[i] = 0; sh_block[i] = 0;
      end
      stg_count = 0;
      stg_seed = 0;
      skew_ms = mwrl_pkg::SKEW_RESET;
      t_now = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed part
      dir = {dir, mk(mwrl_pkg::FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_RETRY, 1, mwrl_pkg::T48, 0, 0, 0, 16'hFFFF, 0, 0, 1, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_QUERY, 1, mwrl_pkg::T48, 0, 0, 0, 0, 0, 0, 1, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_RETRY, 2, 1000, 0, 0, 0, 5, 0, 0, 1, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_QUERY, 2, 1000, 0, 0, 0, 0, 0, 0, 1, 5000, 0)};
      dir = {dir, mk(mwrl_pkg::FN_SEED, 0, 0, 2, 1, 0, 0, 1, 0)};
      dir = {dir, mk(mwrl_pkg::FN_SEED, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_SEED, 0, 0, 0, 2, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_SEED, 0, 0, 3, 0, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_SEED, 0, 0, 1, 1, 0, 0, 0, 1, 1, 0, 1)};
      dir = {dir, mk(mwrl_pkg::FN_NOTE, 0, 100, 0, 0, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_NOTE, 0, 200, 0, 0, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_QUERY, 0, 300, 0, 0, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_SEED, 0, 300, 9, 9, 0, 0, 1, 1)};
      dir = {dir, mk(mwrl_pkg::FN_OBSERVED, 0, 400, 1, 1, 0, 0, 1, 1)};
      dir = {dir, mk(mwrl_pkg::FN_QUERY, 0, 500, 0, 0, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_STATE, 0, 600, 0, 1, 16'hFFFF, 16'hFFFF, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_QUERY, 0, 600, 0, 0, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_NOTE, 0, mwrl_pkg::T48, 0, 0, 0, 0, 0, 0)};
      dir = {dir, mk(mwrl_pkg::FN_OBSERVED, 3, 50, 0, 0, 0, 0, 0, 1)};
      dir = {dir, mk(mwrl_pkg::FN_NOTE, 3, 60, 0, 0, 0, 0, 0, 0)};
      dir = {dir, mk(3'd6, 1, mwrl_pkg::T48, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1,
                     1, 0, 0)};
      dir = {dir, mk(3'd7, 2, 0, 0, 0, 0, 16'hFFFF, 1, 1, 1, 0, 0)};
      foreach (dir[i]) send_req(dir[i].r, dir[i].known, dir[i].delay, dir[i].dropped);
      drain();

      skews = '{16'd0, 16'hFFFF, 16'($urandom()), mwrl_pkg::SKEW_RESET};
      total = 0;
      for (int ph = 0; ph < 4; ph++) begin
         write_skew(skews[ph]);
         quiet = (ph == 2);
         // long receiver hold while the sender keeps offering
         if (ph == 1) hold_len = 400;
         while (total < (ph + 1) * 380) begin
            random_burst(sent);
            total += sent;
         end
         // sender pauses until everything has come back
         drain();
      end
      quiet = 0;

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ files.f @@
rtl/mwrl_pkg.sv
rtl/mwrl_win_ram.sv
rtl/multi_window_rate_limiter.sv
tb/sv/tb.sv
